[hw/rtl/lost_pkg.sv]
// Shared types and constants of the line-of-sight tile marker.
// Used by lost_store and line_of_sight_tile_marker; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lost_pkg;

	localparam int COORD_W = 6;
	localparam int CODE_W  = 7;

	// Tile code that lets the line of sight through
	localparam logic [CODE_W-1:0] FLOOR_CODE = 7'd46;

	// Operation codes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CAST  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	// Write controls sent from the sequencer to the tile store
	typedef struct packed {
		logic code_we;
		logic seen_we;
		logic seen_wd;
	} store_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/lost_store.sv]
// Tile store: code memory and seen-mark memory, one write and one read address.
// Depends on lost_pkg for the code width and the write control struct.
`timescale 1ns / 1ps
`default_nettype none

module lost_store #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12
) (
	input  wire                          clk,
	input  wire  lost_pkg::store_ctl_t   ctl,
	input  wire  [ADDR_W-1:0]            waddr,
	input  wire  [lost_pkg::CODE_W-1:0]  wcode,
	input  wire  [ADDR_W-1:0]            raddr,
	output logic [lost_pkg::CODE_W-1:0]  rcode_q,
	output logic                         rseen_q
);

	logic [lost_pkg::CODE_W-1:0] code_mem [DEPTH];
	logic                        seen_mem [DEPTH];

	// Write tile codes, read with registered data
	always_ff @(posedge clk) begin
		if (ctl.code_we) begin
			code_mem[waddr] <= wcode;
		end
		rcode_q <= code_mem[raddr];
	end

	// Write seen marks, read with registered data
	always_ff @(posedge clk) begin
		if (ctl.seen_we) begin
			seen_mem[waddr] <= ctl.seen_wd;
		end
		rseen_q <= seen_mem[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/line_of_sight_tile_marker.sv]
// Line-of-sight tile marker: tile map with seen marks and a Bresenham line walk.
// Write and read issue a single result; clear sweeps one seen entry per cycle, then issues
// a single result; cast walks the line and issues one beat per marked cell.
// The single read port of the tile store paces the walk: each cell is requested, then checked.
// One item at a time; busy is high until the item's last result is issued.
// Reset clears control only; tile contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module line_of_sight_tile_marker #(
	parameter int MAP_WIDTH  = 64,
	parameter int MAP_HEIGHT = 64
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire  [1:0]                          operation,
	input  wire  [lost_pkg::COORD_W-1:0]        start_x,
	input  wire  [lost_pkg::COORD_W-1:0]        start_y,
	input  wire  [lost_pkg::COORD_W-1:0]        end_x,
	input  wire  [lost_pkg::COORD_W-1:0]        end_y,
	input  wire  [lost_pkg::CODE_W-1:0]         tile_code,
	output logic                                valid,
	output logic [lost_pkg::COORD_W-1:0]        cell_x,
	output logic [lost_pkg::COORD_W-1:0]        cell_y,
	output logic [lost_pkg::CODE_W-1:0]         tile_value,
	output logic                                seen_bit,
	output logic                                marked,
	output logic                                last
);

	localparam int DEPTH  = MAP_WIDTH * MAP_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CW     = lost_pkg::COORD_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ_REQ,
		ST_READ_OUT,
		ST_CLEAR,
		ST_CAST_REQ,
		ST_CAST_CHK,
		ST_CAST_FLUSH
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                x_q, y_q, x0_q, y0_q, x1_q, y1_q;
	logic [CW-1:0]                dx_q, dy_q;
	logic                         sx_q, sy_q;
	logic signed [8:0]            err_q;
	logic [lost_pkg::CODE_W-1:0]  code_q;
	logic                         inmap_q;
	logic                         pend_q;
	logic [CW-1:0]                pend_x_q, pend_y_q;
	logic [ADDR_W-1:0]            clr_q;

	logic                         valid_q, seen_q, marked_q, last_q;
	logic [CW-1:0]                cell_x_q, cell_y_q;
	logic [lost_pkg::CODE_W-1:0]  tile_q;

	logic                         accept;
	logic [CW-1:0]                dx_d, dy_d;
	logic                         cell_in;
	logic [ADDR_W-1:0]            cell_addr;
	logic [ADDR_W-1:0]            waddr;
	lost_pkg::store_ctl_t         ctl;
	logic [lost_pkg::CODE_W-1:0]  rd_code;
	logic                         rd_seen;
	logic                         pass;
	logic                         at_end;
	logic signed [9:0]            e2;
	logic                         step_x, step_y;
	logic signed [8:0]            err_n;
	logic [CW-1:0]                x_n, y_n;

	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// Line extents from the incoming beat
	assign dx_d = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
	assign dy_d = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);

	// Map bounds and linear address of the current cell
	assign cell_in   = ({3'b000, x_q} < 9'(MAP_WIDTH)) && ({3'b000, y_q} < 9'(MAP_HEIGHT));
	assign cell_addr = ADDR_W'(ADDR_W'(y_q) * ADDR_W'(MAP_WIDTH) + ADDR_W'(x_q));

	// Bresenham step from the current error term
	assign e2     = {err_q, 1'b0};
	assign step_x = e2 > -$signed({4'b0000, dy_q});
	assign step_y = e2 < $signed({4'b0000, dx_q});
	assign err_n  = err_q - (step_x ? $signed({3'b000, dy_q}) : 9'sd0)
	              + (step_y ? $signed({3'b000, dx_q}) : 9'sd0);
	assign x_n    = step_x ? (sx_q ? x_q + 1'b1 : x_q - 1'b1) : x_q;
	assign y_n    = step_y ? (sy_q ? y_q + 1'b1 : y_q - 1'b1) : y_q;

	assign pass   = inmap_q && (rd_code == lost_pkg::FLOOR_CODE);
	assign at_end = (x_q == x1_q) && (y_q == y1_q);

	// Drive store writes for the current state
	always_comb begin
		ctl   = '0;
		waddr = cell_addr;
		case (state_q)
			ST_WRITE: begin
				ctl.code_we = cell_in;
				ctl.seen_we = cell_in;
				ctl.seen_wd = 1'b0;
			end
			ST_CLEAR: begin
				ctl.seen_we = 1'b1;
				ctl.seen_wd = 1'b0;
				waddr       = clr_q;
			end
			ST_CAST_CHK: begin
				ctl.seen_we = pass;
				ctl.seen_wd = 1'b1;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	lost_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.waddr   (waddr),
		.wcode   (code_q),
		.raddr   (cell_addr),
		.rcode_q (rd_code),
		.rseen_q (rd_seen)
	);

	// Sequence operations and issue result beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						x_q    <= start_x;
						y_q    <= start_y;
						x0_q   <= start_x;
						y0_q   <= start_y;
						x1_q   <= end_x;
						y1_q   <= end_y;
						dx_q   <= dx_d;
						dy_q   <= dy_d;
						sx_q   <= start_x < end_x;
						sy_q   <= start_y < end_y;
						err_q  <= $signed({3'b000, dx_d}) - $signed({3'b000, dy_d});
						code_q <= tile_code;
						pend_q <= 1'b0;
						clr_q  <= '0;
						case (operation)
							lost_pkg::OP_WRITE: state_q <= ST_WRITE;
							lost_pkg::OP_READ:  state_q <= ST_READ_REQ;
							lost_pkg::OP_CAST:  state_q <= ST_CAST_REQ;
							lost_pkg::OP_CLEAR: state_q <= ST_CLEAR;
							default:            state_q <= ST_IDLE;
						endcase
					end
				end
				ST_WRITE: begin
					valid_q  <= 1'b1;
					cell_x_q <= x_q;
					cell_y_q <= y_q;
					tile_q   <= '0;
					seen_q   <= 1'b0;
					marked_q <= 1'b0;
					last_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				ST_READ_REQ: begin
					inmap_q <= cell_in;
					state_q <= ST_READ_OUT;
				end
				ST_READ_OUT: begin
					valid_q  <= 1'b1;
					cell_x_q <= x_q;
					cell_y_q <= y_q;
					tile_q   <= inmap_q ? rd_code : '0;
					seen_q   <= inmap_q && rd_seen;
					marked_q <= 1'b0;
					last_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				ST_CLEAR: begin
					// Sweep one seen entry per cycle
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						valid_q  <= 1'b1;
						cell_x_q <= '0;
						cell_y_q <= '0;
						tile_q   <= '0;
						seen_q   <= 1'b0;
						marked_q <= 1'b0;
						last_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_CAST_REQ: begin
					inmap_q <= cell_in;
					state_q <= ST_CAST_CHK;
				end
				ST_CAST_CHK: begin
					if (pass) begin
						// Release the held cell, hold this one until the next is known
						if (pend_q) begin
							valid_q  <= 1'b1;
							cell_x_q <= pend_x_q;
							cell_y_q <= pend_y_q;
							tile_q   <= '0;
							seen_q   <= 1'b0;
							marked_q <= 1'b1;
							last_q   <= 1'b0;
						end
						pend_q   <= 1'b1;
						pend_x_q <= x_q;
						pend_y_q <= y_q;
						if (at_end) begin
							state_q <= ST_CAST_FLUSH;
						end else begin
							x_q     <= x_n;
							y_q     <= y_n;
							err_q   <= err_n;
							state_q <= ST_CAST_REQ;
						end
					end else if (pend_q) begin
						state_q <= ST_CAST_FLUSH;
					end else begin
						// Nothing marked: report the start cell
						valid_q  <= 1'b1;
						cell_x_q <= x0_q;
						cell_y_q <= y0_q;
						tile_q   <= '0;
						seen_q   <= 1'b0;
						marked_q <= 1'b0;
						last_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				ST_CAST_FLUSH: begin
					valid_q  <= 1'b1;
					cell_x_q <= pend_x_q;
					cell_y_q <= pend_y_q;
					tile_q   <= '0;
					seen_q   <= 1'b0;
					marked_q <= 1'b1;
					last_q   <= 1'b1;
					pend_q   <= 1'b0;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign valid      = valid_q;
	assign cell_x     = cell_x_q;
	assign cell_y     = cell_y_q;
	assign tile_value = tile_q;
	assign seen_bit   = seen_q;
	assign marked     = marked_q;
	assign last       = last_q;

endmodule

`default_nettype wire
